// ===== rtl/obstacle_inflation_3x3_core_assert.svh =====
// obstacle_inflation_3x3_core_assert.svh: assertion macros for the obstacle inflation core
// used by the top level; empty bodies when SYNTHESIS is defined
// depends on nothing
`ifndef OBSTACLE_INFLATION_3X3_CORE_ASSERT_SVH
`define OBSTACLE_INFLATION_3X3_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OI3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("oi3 core check failed");
// next-cycle implication
`define OI3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("oi3 core check failed");
`else
`define OI3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OI3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/oi3_pkg.sv =====
// oi3_pkg.sv: shared types and constants of the obstacle inflation core
// used by every rtl module of the core; depends on nothing
package oi3_pkg;

	// default sizes
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	// result queue depth (power of two)
	localparam int OUT_DEPTH = 8;

	// register port
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;
	localparam int MAPW_BITS = 12;
	localparam int MAPH_BITS = 13;

	localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OBSTACLE      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_EDGE   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_CORNER = 3'd5;

	// register reset values
	localparam logic [MAPW_BITS-1:0] RST_MAP_WIDTH     = 12'd2048;
	localparam logic [MAPH_BITS-1:0] RST_MAP_HEIGHT    = 13'd2048;
	localparam logic [7:0]           RST_OBSTACLE      = 8'd254;
	localparam logic [7:0]           RST_WEIGHT_CENTER = 8'd254;
	localparam logic [7:0]           RST_WEIGHT_EDGE   = 8'd80;
	localparam logic [7:0]           RST_WEIGHT_CORNER = 8'd50;

	// cost saturation
	localparam logic [7:0] COST_MAX = 8'd255;

	// kernel settings seen by the datapath
	typedef struct packed {
		logic [7:0] obstacle;
		logic [7:0] w_center;
		logic [7:0] w_edge;
		logic [7:0] w_corner;
	} cfg_t;

	// line buffer entry: obstacle flag of the row two up, value of the row above
	typedef struct packed {
		logic       flag;
		logic [7:0] value;
	} line_ent_t;

	// one window column: flag two rows up, value one row up, current value
	typedef struct packed {
		logic       flag;
		logic [7:0] up;
		logic [7:0] cur;
	} win_col_t;

	typedef win_col_t [2:0] win_t;

	// per-word position info for the cell whose cost the word completes
	typedef struct packed {
		logic res;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic frame_end;
	} pos_info_t;

	// one result word
	typedef struct packed {
		logic [7:0] cost;
		logic       frame_end;
	} res_t;

endpackage

// ===== rtl/obstacle_inflation_3x3_core.sv =====
// obstacle_inflation_3x3_core.sv: top level of the 3x3 obstacle inflation core
// raster counters and credit control; uses oi3_regs, oi3_line_buf, oi3_cost,
// oi3_out_fifo, oi3_pkg and obstacle_inflation_3x3_core_assert.svh
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   item     | item_valid, item_ready | cmd, pixel
//   result   | res_valid, res_ready   | cost, frame_end
//   config   | psel, penable, pready  | pwrite, paddr, pwdata, prdata
//
// one word per cycle while credits remain; the line memory is read at launch
// and written back in the next cycle, when a same-column access is forwarded
// a result passes the stage 1, window and stage 3 registers, then the queue
// an 8-entry result queue with credits keeps words flowing while results wait
// reset clears counters and window; the line memory holds no reset value
`include "obstacle_inflation_3x3_core_assert.svh"
module obstacle_inflation_3x3_core #(
	parameter int MAX_WIDTH  = oi3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = oi3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [oi3_pkg::ADDR_W-1:0] paddr,
	input  logic [oi3_pkg::DATA_W-1:0] pwdata,
	output logic [oi3_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic                       cmd,
	input  logic [7:0]                 pixel,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [7:0]                 cost,
	output logic                       frame_end
);
	import oi3_pkg::*;

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int PW    = $clog2(MAX_WIDTH + 2);
	localparam int XW    = ((RW > PW) ? RW : PW) + 1;
	localparam int OCC_W = $clog2(OUT_DEPTH + 1);

	logic [WW-1:0]    eff_w;
	logic [HW-1:0]    eff_h;
	cfg_t             cfg;
	logic             restart;

	logic [AW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PW-1:0]    pend_q;
	logic [OCC_W-1:0] occ_q;

	logic [XW-1:0]    c_x;
	logic [XW-1:0]    r_x;
	logic [XW-1:0]    w_x;
	logic [XW-1:0]    h_x;
	logic [XW-1:0]    p_x;
	logic [XW-1:0]    c1;
	logic [XW-1:0]    r1;
	logic [XW-1:0]    pend_dec;
	logic             wrap;
	logic             last_px;
	logic             in_fire;
	logic             launch;
	logic             res_a;
	logic             res_b;
	logic [7:0]       pix_in;
	pos_info_t        info;
	pos_info_t        info_s1;
	pos_info_t        info_s2;
	logic             valid_s2;
	logic             lb_shift;
	win_t             win;
	logic             cost_valid;
	res_t             cost_res;
	res_t             head;

	oi3_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.cfg     (cfg),
		.restart (restart)
	);

	// accept and filter: a flush only while draining, a pixel only otherwise
	assign item_ready = (occ_q != OCC_W'(OUT_DEPTH));
	assign in_fire    = item_valid & item_ready;
	assign launch     = in_fire && (cmd == (pend_q != '0));
	assign pix_in     = cmd ? 8'd0 : pixel;

	assign c_x      = XW'(col_q);
	assign r_x      = XW'(row_q);
	assign w_x      = XW'(eff_w);
	assign h_x      = XW'(eff_h);
	assign p_x      = XW'(pend_q);
	assign c1       = c_x + XW'(1);
	assign r1       = r_x + XW'(1);
	assign pend_dec = p_x - XW'(1);
	assign wrap     = (c1 >= w_x);
	assign last_px  = (r1 >= h_x) && wrap;

	// which cell this word completes and which neighbors lie in the map
	always_comb begin
		res_a          = (col_q == '0) && (r_x >= XW'(2));
		res_b          = (col_q != '0) && (r_x >= XW'(1));
		info.res       = res_a | res_b;
		info.top_ok    = res_a ? (r_x != XW'(2)) : (r_x != XW'(1));
		info.bot_ok    = res_a ? (r_x <= h_x) : (r_x < h_x);
		info.left_ok   = res_a ? (w_x != XW'(1)) : (c_x != XW'(1));
		info.right_ok  = !res_a;
		info.frame_end = res_a && (r_x == (h_x + XW'(1)));
	end

	// raster position and drain count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (launch) begin
			if (cmd) begin
				pend_q <= PW'(pend_dec);
			end else if (last_px) begin
				pend_q <= PW'(w_x + XW'(1));
			end
			if (cmd && (pend_dec == '0)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= RW'(r1);
			end else begin
				col_q <= AW'(c1);
			end
		end
	end

	// results owed, from acceptance to delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({launch & info.res, res_valid & res_ready})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	oi3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.addr     (col_q),
		.pix      (pix_in),
		.obstacle (cfg.obstacle),
		.shift    (lb_shift),
		.win      (win)
	);

	// position info follows the word to the window
	always_ff @(posedge clk) begin
		if (launch) begin
			info_s1 <= info;
		end
		if (lb_shift) begin
			info_s2 <= info_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= lb_shift & info_s1.res;
		end
	end

	oi3_cost u_cost (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.info_s2   (info_s2),
		.win       (win),
		.cfg       (cfg),
		.res_valid (cost_valid),
		.res       (cost_res)
	);

	oi3_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cost_valid),
		.wr_data  (cost_res),
		.rd_valid (res_valid),
		.rd_ready (res_ready),
		.rd_data  (head)
	);

	assign cost      = head.cost;
	assign frame_end = head.frame_end;

	// checks
	`OI3_ASSERT_IMP(a_res_counted, clk, arst_n, res_valid, occ_q != '0)
	`OI3_ASSERT_IMP(a_col_in_row, clk, arst_n, 1'b1, c_x < w_x)
	`OI3_ASSERT_IMP(a_drain_past_map, clk, arst_n, pend_q != '0, r_x >= h_x)
	`OI3_ASSERT_NXT(a_full_stalls, clk, arst_n, occ_q == OCC_W'(OUT_DEPTH) && !res_ready, !item_ready)

endmodule

// ===== rtl/oi3_regs.sv =====
// oi3_regs.sv: apb-style register file of the obstacle inflation core
// clamps the map size and flags a frame restart; depends on oi3_pkg
module oi3_regs #(
	parameter int MAX_WIDTH  = oi3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = oi3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [oi3_pkg::ADDR_W-1:0]    paddr,
	input  logic [oi3_pkg::DATA_W-1:0]    pwdata,
	output logic [oi3_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
	output logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
	output oi3_pkg::cfg_t                 cfg,
	output logic                          restart
);
	import oi3_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [MAPW_BITS-1:0] map_width_q;
	logic [MAPH_BITS-1:0] map_height_q;
	cfg_t                 cfg_q;
	logic                 wr;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q    <= RST_MAP_WIDTH;
			map_height_q   <= RST_MAP_HEIGHT;
			cfg_q.obstacle <= RST_OBSTACLE;
			cfg_q.w_center <= RST_WEIGHT_CENTER;
			cfg_q.w_edge   <= RST_WEIGHT_EDGE;
			cfg_q.w_corner <= RST_WEIGHT_CORNER;
		end else if (wr) begin
			unique case (idx)
				REG_MAP_WIDTH:     map_width_q    <= pwdata[MAPW_BITS-1:0];
				REG_MAP_HEIGHT:    map_height_q   <= pwdata[MAPH_BITS-1:0];
				REG_OBSTACLE:      cfg_q.obstacle <= pwdata[7:0];
				REG_WEIGHT_CENTER: cfg_q.w_center <= pwdata[7:0];
				REG_WEIGHT_EDGE:   cfg_q.w_edge   <= pwdata[7:0];
				REG_WEIGHT_CORNER: cfg_q.w_corner <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// a new map size starts a new frame
	assign restart = wr && (idx == REG_MAP_WIDTH || idx == REG_MAP_HEIGHT);

	// read back
	always_comb begin
		unique case (idx)
			REG_MAP_WIDTH:     prdata = DATA_W'(map_width_q);
			REG_MAP_HEIGHT:    prdata = DATA_W'(map_height_q);
			REG_OBSTACLE:      prdata = DATA_W'(cfg_q.obstacle);
			REG_WEIGHT_CENTER: prdata = DATA_W'(cfg_q.w_center);
			REG_WEIGHT_EDGE:   prdata = DATA_W'(cfg_q.w_edge);
			REG_WEIGHT_CORNER: prdata = DATA_W'(cfg_q.w_corner);
			default:           prdata = '0;
		endcase
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (map_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(map_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(map_width_q);
		end
		if (map_height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(map_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(map_height_q);
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/oi3_line_buf.sv =====
// oi3_line_buf.sv: line memory with read-modify-write and the 3x3 window
// one synchronous memory holds value and obstacle flag per column; depends on oi3_pkg
module oi3_line_buf #(
	parameter int MAX_WIDTH = oi3_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         launch,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  logic [7:0]                   pix,
	input  logic [7:0]                   obstacle,
	output logic                         shift,
	output oi3_pkg::win_t                win
);
	import oi3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	line_ent_t        mem [MAX_WIDTH];
	line_ent_t        rd_q;
	logic             valid_s1;
	logic [AW-1:0]    addr_s1;
	logic [7:0]       pix_s1;
	logic             byp_s1;
	line_ent_t        byp_data_s1;
	line_ent_t        ent;
	line_ent_t        wr_ent;
	win_col_t         new_col;
	win_t             win_q;

	// forward the entry written at the edge of the read
	assign ent          = byp_s1 ? byp_data_s1 : rd_q;
	assign wr_ent.flag  = (ent.value == obstacle);
	assign wr_ent.value = pix_s1;

	// line memory: read on launch, write back in stage 1
	always_ff @(posedge clk) begin
		if (launch) begin
			rd_q <= mem[addr];
		end
		if (valid_s1) begin
			mem[addr_s1] <= wr_ent;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= launch;
			byp_s1   <= launch && valid_s1 && (addr_s1 == addr);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (launch) begin
			addr_s1     <= addr;
			pix_s1      <= pix;
			byp_data_s1 <= wr_ent;
		end
	end

	// window shift, newest column on the right
	always_comb begin
		new_col.flag = ent.flag;
		new_col.up   = ent.value;
		new_col.cur  = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= {new_col, win_q[2], win_q[1]};
		end
	end

	assign shift = valid_s1;
	assign win   = win_q;

endmodule

// ===== rtl/oi3_cost.sv =====
// oi3_cost.sv: kernel match, weight select and saturating multiply
// with a stage 3 register behind the window; depends on oi3_pkg
module oi3_cost (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  oi3_pkg::pos_info_t info_s2,
	input  oi3_pkg::win_t      win,
	input  oi3_pkg::cfg_t      cfg,
	output logic               res_valid,
	output oi3_pkg::res_t      res
);
	import oi3_pkg::*;

	logic [2:0]  col_ok;
	logic [2:0]  hit_top;
	logic [2:0]  hit_mid;
	logic [2:0]  hit_bot;
	logic        has_center;
	logic        has_edge;
	logic        has_corner;
	logic [7:0]  cand_center;
	logic [7:0]  cand_edge;
	logic [7:0]  cand_corner;
	logic [7:0]  max_ce;
	logic [7:0]  best;
	logic        valid_s3;
	logic [7:0]  v_s3;
	logic [7:0]  best_s3;
	logic        fe_s3;
	logic [15:0] prod;

	// obstacle hits inside the map
	always_comb begin
		col_ok = {info_s2.right_ok, 1'b1, info_s2.left_ok};
		for (int k = 0; k < 3; k++) begin
			hit_top[k] = win[k].flag & info_s2.top_ok & col_ok[k];
			hit_mid[k] = (win[k].up == cfg.obstacle) & col_ok[k];
			hit_bot[k] = (win[k].cur == cfg.obstacle) & info_s2.bot_ok & col_ok[k];
		end
	end

	// largest weight among the hit classes
	assign has_center  = hit_mid[1];
	assign has_edge    = hit_top[1] | hit_bot[1] | hit_mid[0] | hit_mid[2];
	assign has_corner  = hit_top[0] | hit_top[2] | hit_bot[0] | hit_bot[2];
	assign cand_center = has_center ? cfg.w_center : 8'd0;
	assign cand_edge   = has_edge ? cfg.w_edge : 8'd0;
	assign cand_corner = has_corner ? cfg.w_corner : 8'd0;
	assign max_ce      = (cand_center > cand_edge) ? cand_center : cand_edge;
	assign best        = (max_ce > cand_corner) ? max_ce : cand_corner;

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			v_s3    <= win[1].up;
			best_s3 <= best;
			fe_s3   <= info_s2.frame_end;
		end
	end

	// saturating product
	assign prod          = v_s3 * best_s3;
	assign res_valid     = valid_s3;
	assign res.cost      = (prod[15:8] != 8'd0) ? COST_MAX : prod[7:0];
	assign res.frame_end = fe_s3;

endmodule

// ===== rtl/oi3_out_fifo.sv =====
// oi3_out_fifo.sv: result queue between the cost pipeline and the output channel
// depth from oi3_pkg; depends on oi3_pkg
module oi3_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  oi3_pkg::res_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output oi3_pkg::res_t rd_data
);
	import oi3_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	res_t             slot_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_fire;

	assign rd_valid = (cnt_q != '0);
	assign rd_fire  = rd_valid & rd_ready;
	assign rd_data  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, rd_fire})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// tb_top.sv: self-checking bench for obstacle_inflation_3x3_core, a directed word table
// followed by randomized raster frames, checked against an in-bench cost predictor or typed-in costs
// depends on oi3_pkg and the core rtl
`timescale 1ns / 100ps
module tb_top;
	import oi3_pkg::*;

	localparam int MAXW = MAX_WIDTH_DEF;
	localparam int MAXH = MAX_HEIGHT_DEF;

	// word commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// register slots past the last real register
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int ITEM_TARGET   = 850;
	localparam int CALM_TAIL     = 150;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT   = 1000;
	localparam int SHOW_LIMIT    = 10;
	localparam int BIG_PHASE     = 2;
	localparam int BIG_WORDS     = MAXW / 16;
	localparam int DIR_SMALL_AT  = 11;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid;
	logic                item_ready;
	logic                cmd;
	logic [7:0]          pixel;
	logic                res_valid;
	logic                res_ready;
	logic [7:0]          cost;
	logic                frame_end;

	obstacle_inflation_3x3_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cmd(cmd),
		.pixel(pixel),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cost(cost),
		.frame_end(frame_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predictor state: settings, line memory, window, raster position
	logic [MAPW_BITS-1:0] cfg_w;
	logic [MAPH_BITS-1:0] cfg_h;
	logic [7:0]           cfg_obst;
	logic [7:0]           cfg_wc;
	logic [7:0]           cfg_we;
	logic [7:0]           cfg_wk;
	logic [7:0]           line_val [MAXW];
	logic                 line_flag [MAXW];
	logic [7:0]           win [9];
	int unsigned          col_cnt;
	int unsigned          row_cnt;
	int unsigned          owed;

	// costs still due from the core, oldest first
	res_t cost_due [$];

	int unsigned errors;
	int unsigned quiet_cycles;
	int unsigned stall_left;
	bit          gaps_on;
	bit          stalls_on;

	// directed words; cost typed in only for the single-cell map
	typedef struct packed {
		logic       flush;
		logic [7:0] px;
		logic       typed;
		logic [7:0] cost;
		logic       fe;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [24] = '{
		// 1x1 map from zero dimensions: early flush, obstacle, pixel during drain
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd254, 1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd7,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd255, 1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b1, 8'd255, 1'b1},
		'{CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b1, 8'd0,   1'b1},
		'{CMD_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b1, 8'd0,   1'b1},
		// 3x3 map with scattered obstacles
		'{CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd254, 1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd254, 1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd1,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_PIXEL, 8'd254, 1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
		'{CMD_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0}
	};

	function automatic int unsigned eff_width();
		if (cfg_w == 0) return 1;
		if (cfg_w > MAXW) return MAXW;
		return cfg_w;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_h == 0) return 1;
		if (cfg_h > MAXH) return MAXH;
		return cfg_h;
	endfunction

	// cost of the middle cell of window column ccol, sitting at map (pr, pc)
	function automatic logic [7:0] cell_cost_at(int ccol, int unsigned pr, int unsigned pc,
			int unsigned w, int unsigned h);
		int unsigned v;
		int unsigned best;
		int unsigned wt;
		int          col;
		bit          obst;
		v = win[3 + ccol];
		best = 0;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				col = ccol + dx;
				if (dy < 0 && pr == 0) continue;
				if (dy > 0 && pr + 1 >= h) continue;
				if (col < 0 || col > 2) continue;
				if (dx < 0 && pc == 0) continue;
				if (dx > 0 && pc + 1 >= w) continue;
				// top row holds stored flags, lower rows raw values
				if (dy < 0)
					obst = (win[col] != 0);
				else
					obst = (win[(dy + 1)*3 + col] == cfg_obst);
				if (!obst) continue;
				if (dy == 0 && dx == 0)
					wt = cfg_wc;
				else if (dy == 0 || dx == 0)
					wt = cfg_we;
				else
					wt = cfg_wk;
				if (wt > best) best = wt;
			end
		end
		v = v * best;
		return (v > 255) ? COST_MAX : 8'(v);
	endfunction

	task automatic reset_model();
		cfg_w    = RST_MAP_WIDTH;
		cfg_h    = RST_MAP_HEIGHT;
		cfg_obst = RST_OBSTACLE;
		cfg_wc   = RST_WEIGHT_CENTER;
		cfg_we   = RST_WEIGHT_EDGE;
		cfg_wk   = RST_WEIGHT_CORNER;
		for (int i = 0; i < MAXW; i++) begin
			line_val[i]  = 8'd0;
			line_flag[i] = 1'b0;
		end
		for (int i = 0; i < 9; i++) win[i] = 8'd0;
		col_cnt = 0;
		row_cnt = 0;
		owed    = 0;
	endtask

	task automatic apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		case (idx)
			REG_MAP_WIDTH: begin
				cfg_w = val[MAPW_BITS-1:0];
				col_cnt = 0; row_cnt = 0; owed = 0;
			end
			REG_MAP_HEIGHT: begin
				cfg_h = val[MAPH_BITS-1:0];
				col_cnt = 0; row_cnt = 0; owed = 0;
			end
			REG_OBSTACLE:      cfg_obst = val[7:0];
			REG_WEIGHT_CENTER: cfg_wc = val[7:0];
			REG_WEIGHT_EDGE:   cfg_we = val[7:0];
			REG_WEIGHT_CORNER: cfg_wk = val[7:0];
			default: ;
		endcase
	endtask

	// advance the raster by one accepted word, queue the cost it completes
	task automatic inflate_word(input logic is_flush, input logic [7:0] px,
			output bit used, output bit made);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned pr;
		int unsigned pc;
		logic [7:0]  x;
		logic [7:0]  up;
		logic        fl;
		logic [7:0]  cst;
		w = eff_width();
		h = eff_height();
		used = 0;
		made = 0;
		pr = 0;
		pc = 0;
		cst = 8'd0;
		// flush before frame end, or pixel while draining: dropped
		if (is_flush != (owed != 0)) return;
		used = 1;
		x = is_flush ? 8'd0 : px;
		r = row_cnt;
		c = col_cnt;
		// column 0 closes the last cell two rows up
		if (c == 0 && r >= 2) begin
			pr = r - 2;
			pc = w - 1;
			cst = cell_cost_at(2, pr, pc, w, h);
			made = 1;
		end
		// line memory and window shift
		up = line_val[c];
		fl = line_flag[c];
		line_flag[c] = (up == cfg_obst);
		line_val[c] = x;
		for (int k = 0; k < 3; k++) begin
			win[k*3 + 0] = win[k*3 + 1];
			win[k*3 + 1] = win[k*3 + 2];
		end
		win[2] = {7'd0, fl};
		win[5] = up;
		win[8] = x;
		if (c >= 1 && r >= 1) begin
			pr = r - 1;
			pc = c - 1;
			cst = cell_cost_at(1, pr, pc, w, h);
			made = 1;
		end
		// raster position and drain count
		if (is_flush) begin
			owed--;
			if (owed == 0) begin
				row_cnt = 0;
				col_cnt = 0;
			end
		end else if (r + 1 >= h && c + 1 >= w)
			owed = w + 1;
		if (owed != 0 || !is_flush) begin
			col_cnt = c + 1;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt = r + 1;
			end
		end
		if (made)
			cost_due.push_back('{cost: cst, frame_end: (pr == h - 1 && pc == w - 1)});
	endtask

	// register write: setup phase, access phase, then idle
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_reg(idx, val);
		@(posedge clk);
	endtask

	// drive one word, hold until taken, then predict
	task automatic send_word(input logic is_flush, input logic [7:0] px, input logic typed,
			input res_t typed_res, output bit used);
		bit made;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= is_flush;
		pixel      <= px;
		do @(posedge clk); while (!item_ready);
		inflate_word(is_flush, px, used, made);
		if (made && typed)
			cost_due[cost_due.size() - 1] = typed_res;
	endtask

	// sender holds off until every due cost is back and the pipe is empty
	task automatic settle();
		item_valid <= 1'b0;
		while (cost_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// map values lean toward obstacles and free cells
	function automatic logic [7:0] pick_pixel();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 7) return cfg_obst;
		if (sel < 10) return 8'd0;
		if (sel == 10) return 8'd255;
		if (sel == 11) return 8'd1;
		return 8'($urandom_range(0, 255));
	endfunction

	// settings for one random phase; the first ones pin the extremes
	task automatic program_phase(input int unsigned ph);
		int unsigned wsel;
		int unsigned hsel;
		case (ph)
			0: begin
				reg_write(REG_MAP_WIDTH, 32'd2);
				reg_write(REG_MAP_HEIGHT, 32'd2);
				reg_write(REG_OBSTACLE, 32'd255);
				reg_write(REG_WEIGHT_CENTER, 32'd255);
				reg_write(REG_WEIGHT_EDGE, 32'd255);
				reg_write(REG_WEIGHT_CORNER, 32'd255);
			end
			1: begin
				reg_write(REG_MAP_WIDTH, 32'd1);
				reg_write(REG_MAP_HEIGHT, MAXH);
				reg_write(REG_OBSTACLE, 32'd0);
				reg_write(REG_WEIGHT_CENTER, 32'd0);
				reg_write(REG_WEIGHT_EDGE, 32'd0);
				reg_write(REG_WEIGHT_CORNER, 32'd0);
			end
			BIG_PHASE: begin
				// oversize dimensions clamp; spare slots must change nothing
				reg_write(REG_MAP_WIDTH, 32'hFFF);
				reg_write(REG_MAP_HEIGHT, 32'h1FFF);
				reg_write(REG_OBSTACLE, 32'd254);
				reg_write(REG_WEIGHT_CENTER, 32'd3);
				reg_write(REG_WEIGHT_EDGE, 32'd2);
				reg_write(REG_WEIGHT_CORNER, 32'd1);
				reg_write(REG_SPARE_A, $urandom);
				reg_write(REG_SPARE_B, $urandom);
			end
			default: begin
				if ($urandom_range(0, 4) < 2) begin
					wsel = $urandom_range(0, 9);
					hsel = $urandom_range(0, 9);
					reg_write(REG_MAP_WIDTH, (wsel < 7) ? $urandom_range(1, 8) :
						(wsel < 9) ? $urandom_range(9, 48) : $urandom_range(0, 2));
					reg_write(REG_MAP_HEIGHT, (hsel < 7) ? $urandom_range(1, 6) :
						(hsel < 9) ? $urandom_range(7, 20) : $urandom_range(0, 1));
				end
				if ($urandom_range(0, 4) < 2) reg_write(REG_OBSTACLE, pick_byte());
				if ($urandom_range(0, 4) < 2) reg_write(REG_WEIGHT_CENTER, pick_byte());
				if ($urandom_range(0, 4) < 2) reg_write(REG_WEIGHT_EDGE, pick_byte());
				if ($urandom_range(0, 4) < 2) reg_write(REG_WEIGHT_CORNER, pick_byte());
			end
		endcase
	endtask

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stalls_on && stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready  <= (stall_left == 1);
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 14);
			res_ready  <= 1'b0;
		end else
			res_ready <= 1'b1;
	end

	// compare each returned word with the oldest due cost
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (cost_due.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("unexpected word: cost %0d frame_end %0d", cost, frame_end);
			end else begin
				want = cost_due.pop_front();
				if (cost !== want.cost || frame_end !== want.frame_end) begin
					errors++;
					if (errors <= SHOW_LIMIT)
						$display("mismatch: want cost %0d frame_end %0d, got cost %0d frame_end %0d",
							want.cost, want.frame_end, cost, frame_end);
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("obstacle_inflation_3x3_core regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// main sequence
	initial begin
		int unsigned counted;
		int unsigned n_words;
		int unsigned ph;
		bit          used;
		bit          want_flush;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		item_valid   <= 1'b0;
		cmd          <= CMD_PIXEL;
		pixel        <= 8'd0;
		res_ready    <= 1'b0;
		arst_n       <= 1'b0;
		stall_left   = 0;
		quiet_cycles = 0;
		errors       = 0;
		gaps_on      = 1;
		stalls_on    = 1;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: single cell map first, then a 3x3 map
		reg_write(REG_MAP_WIDTH, 32'd0);
		reg_write(REG_MAP_HEIGHT, 32'd0);
		for (int i = 0; i < 24; i++) begin
			if (i == DIR_SMALL_AT) begin
				settle();
				reg_write(REG_MAP_WIDTH, 32'd3);
				reg_write(REG_MAP_HEIGHT, 32'd3);
			end
			send_word(DIR_ROWS[i].flush, DIR_ROWS[i].px, DIR_ROWS[i].typed,
				'{cost: DIR_ROWS[i].cost, frame_end: DIR_ROWS[i].fe}, used);
		end

		// random phases of raster frames, mostly well formed
		counted = 0;
		ph = 0;
		while (counted < ITEM_TARGET) begin
			settle();
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			if (counted + CALM_TAIL >= ITEM_TARGET) begin
				gaps_on   = 0;
				stalls_on = 0;
			end
			program_phase(ph);
			n_words = (ph == BIG_PHASE) ? BIG_WORDS : $urandom_range(20, 120);
			repeat (n_words) begin
				if (owed != 0)
					want_flush = ($urandom_range(0, 24) != 0);
				else
					want_flush = ($urandom_range(0, 24) == 0);
				send_word(want_flush, pick_pixel(), 1'b0, '0, used);
				if (used) counted++;
			end
			ph++;
		end

		// drain and report
		settle();
		if (errors == 0)
			$display("obstacle_inflation_3x3_core regression: pass");
		else
			$display("obstacle_inflation_3x3_core regression: fail");
		$finish;
	end

endmodule
